// File: src/buf_uart_pkg.sv
// ----------------------------------------------------------------------------
// buf_uart_pkg
// Shared types and constants of the buffered UART FIFO front end.
// ----------------------------------------------------------------------------
package buf_uart_pkg;

  localparam int unsigned FifoDepthDefault = 16;

  typedef enum logic [2:0] {
    CMD_RX_BYTE = 3'd0,
    CMD_TX_SLOT = 3'd1,
    CMD_PUT     = 3'd2,
    CMD_GET     = 3'd3,
    CMD_STATUS  = 3'd4
  } cmd_e;

  // Per-word result flags handed from the control unit to the output pipeline.
  typedef struct packed {
    logic       byte_valid;
    logic       from_rx;
    logic       accepted;
    logic [2:0] error_status;
    logic       in_ready;
    logic       out_ready;
    logic       tx_irq_enable;
  } res_t;

endpackage

// File: src/buf_uart_ram.sv
// ----------------------------------------------------------------------------
// buf_uart_ram
// Byte-wide FIFO storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module buf_uart_ram #(
  parameter int unsigned FIFO_DEPTH = buf_uart_pkg::FifoDepthDefault,
  localparam int unsigned AW = $clog2(FIFO_DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [FIFO_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold the read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/buf_uart_ctrl.sv
// ----------------------------------------------------------------------------
// buf_uart_ctrl
// Pointers, counts, error register and transmit interrupt flag; issues the
// FIFO memory reads and writes that each accepted word calls for.
// ----------------------------------------------------------------------------
module buf_uart_ctrl #(
  parameter int unsigned FIFO_DEPTH = buf_uart_pkg::FifoDepthDefault,
  localparam int unsigned AW = $clog2(FIFO_DEPTH),
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  buf_uart_pkg::cmd_e  cmd_i,
  input  logic                rx_overrun_i,
  input  logic                rx_framing_i,
  output logic                rx_we_o,
  output logic [AW-1:0]       rx_waddr_o,
  output logic                rx_re_o,
  output logic [AW-1:0]       rx_raddr_o,
  output logic                tx_we_o,
  output logic [AW-1:0]       tx_waddr_o,
  output logic                tx_re_o,
  output logic [AW-1:0]       tx_raddr_o,
  output buf_uart_pkg::res_t  res_o
);

  localparam logic [AW-1:0] LastPtr = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(FIFO_DEPTH);

  logic [AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [AW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [CW-1:0] rx_count_q, rx_count_d, tx_count_q, tx_count_d;
  logic [2:0]    err_q, err_d;
  logic          flag_q, flag_d;

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
    return (p == LastPtr) ? '0 : AW'(p + 1'b1);
  endfunction

  always_comb begin
    rx_head_d  = rx_head_q;
    rx_tail_d  = rx_tail_q;
    rx_count_d = rx_count_q;
    tx_head_d  = tx_head_q;
    tx_tail_d  = tx_tail_q;
    tx_count_d = tx_count_q;
    err_d      = err_q;
    flag_d     = flag_q;
    rx_we_o    = 1'b0;
    rx_re_o    = 1'b0;
    tx_we_o    = 1'b0;
    tx_re_o    = 1'b0;
    res_o      = '0;
    if (step_i) begin
      case (cmd_i)
        buf_uart_pkg::CMD_RX_BYTE: begin
          err_d = {rx_framing_i, rx_overrun_i, 1'b0};
          if (rx_count_q == FullCnt) begin
            err_d[0] = 1'b1;  // drop the byte, flag overflow
          end else begin
            rx_we_o        = 1'b1;
            rx_tail_d      = wrap_next(rx_tail_q);
            rx_count_d     = CW'(rx_count_q + 1'b1);
            res_o.accepted = 1'b1;
          end
        end
        buf_uart_pkg::CMD_TX_SLOT: begin
          if (flag_q) begin
            if (tx_count_q == '0) begin
              flag_d = 1'b0;
            end else begin
              tx_re_o          = 1'b1;
              tx_head_d        = wrap_next(tx_head_q);
              tx_count_d       = CW'(tx_count_q - 1'b1);
              res_o.byte_valid = 1'b1;
            end
          end
        end
        buf_uart_pkg::CMD_PUT: begin
          if (tx_count_q != FullCnt) begin
            tx_we_o        = 1'b1;
            tx_tail_d      = wrap_next(tx_tail_q);
            tx_count_d     = CW'(tx_count_q + 1'b1);
            flag_d         = 1'b1;
            res_o.accepted = 1'b1;
          end
        end
        buf_uart_pkg::CMD_GET: begin
          if (rx_count_q != '0) begin
            rx_re_o          = 1'b1;
            rx_head_d        = wrap_next(rx_head_q);
            rx_count_d       = CW'(rx_count_q - 1'b1);
            res_o.byte_valid = 1'b1;
            res_o.from_rx    = 1'b1;
          end
        end
        buf_uart_pkg::CMD_STATUS: begin
          res_o.error_status = err_q;
          err_d              = '0;
        end
        default: begin
        end
      endcase
    end
    res_o.in_ready      = (rx_count_d != '0);
    res_o.out_ready     = (tx_count_d != FullCnt);
    res_o.tx_irq_enable = flag_d;
  end

  assign rx_waddr_o = rx_tail_q;
  assign rx_raddr_o = rx_head_q;
  assign tx_waddr_o = tx_tail_q;
  assign tx_raddr_o = tx_head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q  <= '0;
      rx_tail_q  <= '0;
      rx_count_q <= '0;
      tx_head_q  <= '0;
      tx_tail_q  <= '0;
      tx_count_q <= '0;
      err_q      <= '0;
      flag_q     <= 1'b0;
    end else begin
      rx_head_q  <= rx_head_d;
      rx_tail_q  <= rx_tail_d;
      rx_count_q <= rx_count_d;
      tx_head_q  <= tx_head_d;
      tx_tail_q  <= tx_tail_d;
      tx_count_q <= tx_count_d;
      err_q      <= err_d;
      flag_q     <= flag_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_count_q <= FullCnt) && (tx_count_q <= FullCnt))
    else $error("FIFO count beyond depth");

  a_rx_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_count_q == '0) |-> (rx_head_q == rx_tail_q))
    else $error("rx FIFO empty but pointers differ");

  a_tx_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_count_q == FullCnt) |-> (tx_head_q == tx_tail_q))
    else $error("tx FIFO full but pointers differ");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(rx_count_q) && $stable(tx_count_q) && $stable(flag_q))
    else $error("state changed without an accepted word");

endmodule

// File: src/buffered_uart_fifo_front_end.sv
// ----------------------------------------------------------------------------
// buffered_uart_fifo_front_end
// One-channel UART host front end: receive and transmit byte FIFOs in
// synchronous RAM, error register and transmit interrupt enable flag.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word's RAM read and flags register into the read stage,
//   then into the output register when free or drained. One word per cycle
//   unless res_stall_i backs up; each word touches at most one FIFO RAM port.
// Reset: pointers, counts, error bits, flag and pipeline valids clear at once;
//   FIFO RAM contents are undefined until written, and no clearing pass runs.
module buffered_uart_fifo_front_end #(
  parameter int unsigned FIFO_DEPTH = buf_uart_pkg::FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] data_byte_i,
  input  logic       rx_overrun_i,
  input  logic       rx_framing_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       accepted_o,
  output logic [2:0] error_status_o,
  output logic       in_ready_o,
  output logic       out_ready_o,
  output logic       tx_irq_enable_o
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);

  buf_uart_pkg::cmd_e cmd;
  buf_uart_pkg::res_t res;
  buf_uart_pkg::res_t s1_res_q;
  buf_uart_pkg::res_t o_res_q;
  logic               s1_valid_q;
  logic               o_valid_q;
  logic [7:0]         o_byte_q;
  logic               step;
  logic               s1_adv;
  logic               rx_we, rx_re, tx_we, tx_re;
  logic [AW-1:0]      rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [7:0]         rx_rdata, tx_rdata;

  assign cmd = buf_uart_pkg::cmd_e'(cmd_i);

  // Advance the read stage whenever the output register is free or drained.
  assign s1_adv     = s1_valid_q && (!o_valid_q || !res_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign step       = in_valid_i && !in_stall_o;

  buf_uart_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .cmd_i        (cmd),
    .rx_overrun_i (rx_overrun_i),
    .rx_framing_i (rx_framing_i),
    .rx_we_o      (rx_we),
    .rx_waddr_o   (rx_waddr),
    .rx_re_o      (rx_re),
    .rx_raddr_o   (rx_raddr),
    .tx_we_o      (tx_we),
    .tx_waddr_o   (tx_waddr),
    .tx_re_o      (tx_re),
    .tx_raddr_o   (tx_raddr),
    .res_o        (res)
  );

  buf_uart_ram #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (data_byte_i),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  buf_uart_ram #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (data_byte_i),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (step) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        o_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_res_q <= res;
    end
    if (s1_adv) begin
      o_res_q <= s1_res_q;
      if (!s1_res_q.byte_valid) begin
        o_byte_q <= '0;
      end else if (s1_res_q.from_rx) begin
        o_byte_q <= rx_rdata;
      end else begin
        o_byte_q <= tx_rdata;
      end
    end
  end

  assign res_valid_o     = o_valid_q;
  assign out_byte_o      = o_byte_q;
  assign out_valid_o     = o_res_q.byte_valid;
  assign accepted_o      = o_res_q.accepted;
  assign error_status_o  = o_res_q.error_status;
  assign in_ready_o      = o_res_q.in_ready;
  assign out_ready_o     = o_res_q.out_ready;
  assign tx_irq_enable_o = o_res_q.tx_irq_enable;

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buffered UART FIFO front end. A negedge driver
// feeds command words from a queue and a posedge monitor compares each result
// word with the output of a cycle-free predictor of both FIFOs, the error
// register and the transmit interrupt enable flag.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = buf_uart_pkg::FifoDepthDefault;
  localparam int PtrW  = $clog2(Depth);
  localparam int NumWords = 1050;

  typedef struct {
    logic [2:0] cmd;
    logic [7:0] data;
    logic       overrun;
    logic       framing;
  } uart_word_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       accepted;
    logic [2:0] error_status;
    logic       in_ready;
    logic       out_ready;
    logic       tx_irq_enable;
  } uart_res_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] cmd_i = '0;
  logic [7:0] data_byte_i = '0;
  logic       rx_overrun_i = 1'b0;
  logic       rx_framing_i = 1'b0;
  logic       res_valid_o;
  logic       res_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_valid_o;
  logic       accepted_o;
  logic [2:0] error_status_o;
  logic       in_ready_o;
  logic       out_ready_o;
  logic       tx_irq_enable_o;

  buffered_uart_fifo_front_end dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .data_byte_i    (data_byte_i),
    .rx_overrun_i   (rx_overrun_i),
    .rx_framing_i   (rx_framing_i),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .out_byte_o     (out_byte_o),
    .out_valid_o    (out_valid_o),
    .accepted_o     (accepted_o),
    .error_status_o (error_status_o),
    .in_ready_o     (in_ready_o),
    .out_ready_o    (out_ready_o),
    .tx_irq_enable_o(tx_irq_enable_o)
  );

  uart_word_t word_q[$];
  uart_res_t  result_q[$];
  uart_res_t  want;

  // predicted block state
  logic [7:0]    rx_mem[Depth];
  logic [7:0]    tx_mem[Depth];
  logic [PtrW-1:0] rx_rd, rx_wr, tx_rd, tx_wr;
  logic [PtrW:0]   rx_cnt, tx_cnt;
  logic [2:0]    err_bits;
  logic          irq_en;

  int  n_words;
  int  n_bad;
  int  in_gap;
  int  stall_left;
  int  gap_pct;
  int  stall_pct;
  int  cyc_cnt;
  bit  in_took;
  bit  tail_phase;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Apply one command word to the predicted state and return its result word.
  function automatic uart_res_t uart_step(uart_word_t w);
    uart_res_t r;
    r = '{default: '0};
    case (w.cmd)
      buf_uart_pkg::CMD_RX_BYTE: begin
        err_bits = {w.framing, w.overrun, 1'b0};
        if (rx_cnt == Depth) begin
          err_bits[0] = 1'b1;
        end else begin
          rx_mem[rx_wr] = w.data;
          rx_wr = ptr_next(rx_wr);
          rx_cnt++;
          r.accepted = 1'b1;
        end
      end
      buf_uart_pkg::CMD_TX_SLOT: begin
        if (irq_en) begin
          if (tx_cnt == 0) begin
            irq_en = 1'b0;
          end else begin
            r.out_byte = tx_mem[tx_rd];
            r.out_valid = 1'b1;
            tx_rd = ptr_next(tx_rd);
            tx_cnt--;
          end
        end
      end
      buf_uart_pkg::CMD_PUT: begin
        if (tx_cnt < Depth) begin
          tx_mem[tx_wr] = w.data;
          tx_wr = ptr_next(tx_wr);
          tx_cnt++;
          r.accepted = 1'b1;
          irq_en = 1'b1;
        end
      end
      buf_uart_pkg::CMD_GET: begin
        if (rx_cnt != 0) begin
          r.out_byte = rx_mem[rx_rd];
          r.out_valid = 1'b1;
          rx_rd = ptr_next(rx_rd);
          rx_cnt--;
        end
      end
      buf_uart_pkg::CMD_STATUS: begin
        r.error_status = err_bits;
        err_bits = '0;
      end
      default: ;
    endcase
    r.in_ready = (rx_cnt != 0);
    r.out_ready = (tx_cnt < Depth);
    r.tx_irq_enable = irq_en;
    return r;
  endfunction

  function automatic void chk_field(string fld, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      n_bad++;
      if (n_bad <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, exp_v, act_v);
    end
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  task automatic add_word(logic [2:0] c, logic [7:0] d, logic ovr, logic frm);
    uart_word_t w;
    w.cmd = c;
    w.data = d;
    w.overrun = ovr;
    w.framing = frm;
    word_q.push_back(w);
    if (c <= buf_uart_pkg::CMD_STATUS) n_words++;
  endtask

  // Monitor the result side first, then take the accepted command word.
  always @(posedge clk_i) begin
    in_took = 1'b0;
    if (rst_ni) begin
      if (res_valid_o && !res_stall_i) begin
        if (result_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("%0t: result word with none expected", $time);
        end else begin
          want = result_q.pop_front();
          chk_field("out_byte", want.out_byte, out_byte_o);
          chk_field("out_valid", 8'(want.out_valid), 8'(out_valid_o));
          chk_field("accepted", 8'(want.accepted), 8'(accepted_o));
          chk_field("error_status", 8'(want.error_status), 8'(error_status_o));
          chk_field("in_ready", 8'(want.in_ready), 8'(in_ready_o));
          chk_field("out_ready", 8'(want.out_ready), 8'(out_ready_o));
          chk_field("tx_irq_enable", 8'(want.tx_irq_enable), 8'(tx_irq_enable_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        in_took = 1'b1;
        result_q.push_back(uart_step(word_q.pop_front()));
      end
      tail_phase = (word_q.size() < 120);
    end
  end

  // Command driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      // hold the stalled word
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid_i <= 1'b0;
    end else if (!tail_phase && $urandom_range(99) < gap_pct) begin
      in_gap = $urandom_range(7);
      in_valid_i <= 1'b0;
    end else if (word_q.size() != 0) begin
      in_valid_i <= 1'b1;
      cmd_i <= word_q[0].cmd;
      data_byte_i <= word_q[0].data;
      rx_overrun_i <= word_q[0].overrun;
      rx_framing_i <= word_q[0].framing;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Result stall driver; also reshuffles the idle rates now and then
  always @(negedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt % 64 == 0) begin
      gap_pct = pick_pct();
      stall_pct = pick_pct();
    end
    if (!rst_ni) begin
      res_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall_i <= 1'b1;
    end else if (!tail_phase && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(7);
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= 1'b0;
    end
  end

  initial begin
    int kind;
    int len;
    rx_rd = '0; rx_wr = '0; rx_cnt = '0;
    tx_rd = '0; tx_wr = '0; tx_cnt = '0;
    err_bits = '0;
    irq_en = 1'b0;

    // directed corners
    add_word(buf_uart_pkg::CMD_STATUS, 8'h00, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_GET, 8'hFF, 1'b1, 1'b1);
    add_word(buf_uart_pkg::CMD_TX_SLOT, 8'h5A, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_RX_BYTE, 8'hFF, 1'b1, 1'b1);
    add_word(buf_uart_pkg::CMD_STATUS, 8'h00, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_STATUS, 8'h00, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_RX_BYTE, 8'h00, 1'b0, 1'b1);
    add_word(buf_uart_pkg::CMD_RX_BYTE, 8'h81, 1'b1, 1'b0);
    add_word(buf_uart_pkg::CMD_STATUS, 8'hFF, 1'b1, 1'b1);
    add_word(buf_uart_pkg::CMD_PUT, 8'hA5, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_PUT, 8'h00, 1'b1, 1'b1);
    add_word(buf_uart_pkg::CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_TX_SLOT, 8'hFF, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_TX_SLOT, 8'h00, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_GET, 8'h00, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_GET, 8'h00, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_GET, 8'h00, 1'b0, 1'b0);
    add_word(buf_uart_pkg::CMD_GET, 8'h00, 1'b0, 1'b0);
    add_word(3'd5, 8'hFF, 1'b1, 1'b1);
    add_word(3'd6, 8'h55, 1'b0, 1'b1);
    add_word(3'd7, 8'hAA, 1'b1, 1'b0);
    add_word(buf_uart_pkg::CMD_STATUS, 8'h00, 1'b0, 1'b0);

    // random runs that fill and drain both FIFOs past their limits
    while (n_words < NumWords) begin
      kind = $urandom_range(9);
      len = $urandom_range(1, 20);
      case (kind)
        0, 1: repeat (len) add_word(buf_uart_pkg::CMD_RX_BYTE, 8'($urandom_range(255)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)));
        2, 3: repeat (len) add_word(buf_uart_pkg::CMD_GET, 8'($urandom_range(255)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)));
        4, 5: repeat (len) add_word(buf_uart_pkg::CMD_PUT, 8'($urandom_range(255)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)));
        6, 7: repeat (len) add_word(buf_uart_pkg::CMD_TX_SLOT, 8'($urandom_range(255)),
                                    1'($urandom_range(1)), 1'($urandom_range(1)));
        8: add_word(buf_uart_pkg::CMD_STATUS, 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        default: repeat (len % 4 + 1) add_word(3'($urandom_range(7)),
                                               8'($urandom_range(255)),
                                               1'($urandom_range(1)),
                                               1'($urandom_range(1)));
      endcase
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (word_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
